@@ rtl/core/plt_pkg.sv @@
package plt_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int EXPONENT_BITS  = 8;

  // components keep the low bits of their 16-bit slot, sign-extended
  localparam int VecBits   = (COMPONENT_BITS < 16) ? COMPONENT_BITS : 16;
  localparam int CompShift = 16 - VecBits;

  localparam int QueueDepth = 2;

  localparam logic [1:0] OP_AMBIENT  = 2'd0;
  localparam logic [1:0] OP_DIFFUSE  = 2'd1;
  localparam logic [1:0] OP_SPECULAR = 2'd2;
  localparam logic [1:0] OP_REFLECT  = 2'd3;

  localparam logic [1:0] VEC_L = 2'd0;
  localparam logic [1:0] VEC_N = 2'd1;
  localparam logic [1:0] VEC_V = 2'd2;

  typedef enum logic [1:0] {
    KIND_FLAT,
    KIND_DIFFUSE,
    KIND_SPECULAR
  } plt_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_DOT,
    ST_PROD,
    ST_SQRT,
    ST_DIV,
    ST_COMB,
    ST_POW,
    ST_CHAN,
    ST_DONE
  } plt_state_e;

  typedef struct packed {
    plt_kind_e                kind;
    logic                     start;
    logic [2:0][7:0]          light;
    logic [2:0][15:0]         coeff;
    logic [2:0][2:0][15:0]    vecs;
    logic [EXPONENT_BITS-1:0] expo;
  } plt_item_t;

  function automatic logic [15:0] sext_comp(input logic [15:0] v);
    logic [15:0] m;
    m = v << CompShift;
    return 16'($signed(m) >>> CompShift);
  endfunction

endpackage

@@ rtl/core/plt_front.sv @@
module plt_front import plt_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic        start_req_i,
  input  logic [23:0] light_rgb_i,
  input  logic [47:0] coeff_rgb_i,
  input  logic [47:0] normal_vec_i,
  input  logic [47:0] light_vec_i,
  input  logic [47:0] view_vec_i,
  input  logic [7:0]  shininess_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output plt_item_t   q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.start = start_req_i;
    q_item_o.light = light_rgb_i;
    q_item_o.coeff = coeff_rgb_i;
    q_item_o.expo  = EXPONENT_BITS'(shininess_i);
    case (op_i)
      OP_DIFFUSE:  q_item_o.kind = KIND_DIFFUSE;
      OP_SPECULAR: q_item_o.kind = KIND_SPECULAR;
      OP_AMBIENT, OP_REFLECT: q_item_o.kind = KIND_FLAT;
      default:     q_item_o.kind = KIND_FLAT;
    endcase
    for (int c = 0; c < 3; c++) begin
      q_item_o.vecs[VEC_L][c] = sext_comp(light_vec_i[16*c +: 16]);
      q_item_o.vecs[VEC_N][c] = sext_comp(normal_vec_i[16*c +: 16]);
      q_item_o.vecs[VEC_V][c] = sext_comp(view_vec_i[16*c +: 16]);
    end
  end

endmodule

@@ rtl/core/plt_queue.sv @@
module plt_queue import plt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  plt_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output plt_item_t item_o
);

  localparam int PtrBits = $clog2(QueueDepth);

  plt_item_t          mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = cnt_q == (PtrBits+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/plt_back.sv @@
module plt_back import plt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  plt_item_t          q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        term_rgb_o,
  output logic [23:0]        merged_rgb_o,
  output logic signed [15:0] cosine_o
);

  // floor(2^32 / 255), corrected by one compare afterwards
  localparam logic signed [32:0] Recip255 = 33'sd16843009;
  localparam logic [4:0] PowLast = 5'(2*EXPONENT_BITS-1);

  function automatic logic signed [32:0] sx(input logic [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  plt_state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic [1:0] ci_q, vi_q, pair_q, ch_q;
  logic       q_pop, out_load;

  plt_item_t          item_q;
  logic [31:0]        nrm_q [3];
  logic signed [34:0] acc_q, acc_sum, negd;
  logic [31:0]        dmag;
  logic               dneg_q;
  logic [63:0]        sqv_q, res_q, bit_q;
  logic [64:0]        trial;
  logic               sq_ge;
  logic [46:0]        rem_q, dv_q;
  logic [15:0]        quo_q, quo_nx, cmag;
  logic               div_ge;
  logic [16:0]        cneg;
  logic signed [15:0] cos_q [3];
  logic signed [15:0] cos_nx, cosv_q, sat_cos;
  logic signed [32:0] comb_q;
  logic signed [33:0] prod2, tsh;
  logic signed [18:0] tq;
  logic signed [19:0] diff;
  logic [15:0]        base_q;
  logic [16:0]        pres_q, factor_q;
  logic [EXPONENT_BITS-1:0] expo_q;
  logic [23:0]        kl_q;
  logic [39:0]        prod_q;
  logic [25:0]        xq, q0x255, rr;
  logic [17:0]        q0_q, qq;
  logic [40:0]        rnd;
  logic [10:0]        r8;
  logic [7:0]         t8_q, t8, m8;
  logic [15:0]        level_q, level, mnew;
  logic [16:0]        p_q, mdiff;
  logic [23:0]        m255, m8s;
  logic [2:0][7:0]    term_acc_q, mrg_acc_q;
  logic [15:0]        merged_q [3];
  logic               out_valid_q;
  logic [23:0]        term_out_q, mrg_out_q;
  logic signed [15:0] cos_out_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [1:0]         va, vb;

  assign q_pop_o      = q_pop;
  assign out_valid_o  = out_valid_q;
  assign term_rgb_o   = term_out_q;
  assign merged_rgb_o = mrg_out_q;
  assign cosine_o     = cos_out_q;

  // vector pair of each cosine: LN, NV, LV
  always_comb begin
    case (pair_q)
      2'd0:    begin va = VEC_L; vb = VEC_N; end
      2'd1:    begin va = VEC_N; vb = VEC_V; end
      default: begin va = VEC_L; vb = VEC_V; end
    endcase
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_NORM: begin
        mul_a = sx(item_q.vecs[vi_q][ci_q]);
        mul_b = sx(item_q.vecs[vi_q][ci_q]);
      end
      ST_DOT: begin
        mul_a = sx(item_q.vecs[va][ci_q]);
        mul_b = sx(item_q.vecs[vb][ci_q]);
      end
      ST_PROD: begin
        mul_a = {1'b0, nrm_q[va]};
        mul_b = {1'b0, nrm_q[vb]};
      end
      ST_COMB: begin
        mul_a = sx(cos_q[0]);
        mul_b = sx(cos_q[1]);
      end
      ST_POW: begin
        mul_a = cnt_q[0] ? {17'b0, base_q} : {16'b0, pres_q};
        mul_b = {17'b0, base_q};
      end
      ST_CHAN: begin
        case (cnt_q)
          5'd0: begin
            mul_a = {17'b0, item_q.coeff[ch_q]};
            mul_b = {25'b0, item_q.light[ch_q]};
          end
          5'd1: begin
            mul_a = {9'b0, kl_q};
            mul_b = {16'b0, factor_q};
          end
          5'd2: begin
            mul_a = {7'b0, xq};
            mul_b = Recip255;
          end
          5'd4: begin
            mul_a = {16'b0, 17'd65536 - {1'b0, merged_q[ch_q]}};
            mul_b = {16'b0, 17'd65536 - {1'b0, level_q}};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    acc_sum = acc_q + $signed(mul_p[34:0]);
    negd    = -acc_sum;
    dmag    = (acc_sum < 0) ? negd[31:0] : acc_sum[31:0];

    trial = {1'b0, res_q} + {1'b0, bit_q};
    sq_ge = {1'b0, sqv_q} >= trial;

    div_ge = rem_q >= dv_q;
    quo_nx = {quo_q[14:0], div_ge};
    cmag   = (quo_nx > 16'd32768) ? 16'd32768 : quo_nx;
    cneg   = 17'd0 - {1'b0, cmag};
    if (res_q == '0) begin
      cos_nx = '0;
    end else if (dneg_q) begin
      cos_nx = cneg[15:0];
    end else begin
      cos_nx = (quo_nx > 16'd32767) ? 16'sd32767 : quo_nx;
    end

    // truncating divide by 2^15 of the doubled product
    prod2 = {comb_q, 1'b0};
    tsh   = (prod2 < 0) ? ((prod2 + 34'sd32767) >>> 15) : (prod2 >>> 15);
    tq    = tsh[18:0];
    diff  = {tq[18], tq} - {{4{cos_q[2][15]}}, cos_q[2]};
    if (diff > 20'sd32767) begin
      sat_cos = 16'sd32767;
    end else if (diff < -20'sd32768) begin
      sat_cos = -16'sd32768;
    end else begin
      sat_cos = diff[15:0];
    end

    xq  = prod_q[39:14];
    rnd = {1'b0, prod_q} + 41'(1 << 29);
    r8  = rnd[40:30];
    t8  = (r8 > 11'd255) ? 8'd255 : r8[7:0];

    q0x255 = {q0_q, 8'b0} - {8'b0, q0_q};
    rr     = xq - q0x255;
    qq     = q0_q + {17'b0, rr >= 26'd255};
    level  = (qq > 18'd65535) ? 16'hFFFF : qq[15:0];

    mdiff = 17'd65536 - p_q;
    if (item_q.start) begin
      mnew = level_q;
    end else begin
      mnew = (mdiff > 17'd65535) ? 16'hFFFF : mdiff[15:0];
    end
    m255 = {mnew, 8'b0} - {8'b0, mnew};
    m8s  = m255 + 24'd32768;
    m8   = m8s[23:16];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.kind == KIND_FLAT) ? ST_CHAN : ST_NORM;
        end
      end
      ST_NORM: if (vi_q == 2'd2 && ci_q == 2'd2) state_d = ST_DOT;
      ST_DOT:  if (ci_q == 2'd2) state_d = ST_PROD;
      ST_PROD: state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == 5'd31) state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 5'd16) begin
          if (item_q.kind == KIND_DIFFUSE) begin
            state_d = ST_CHAN;
          end else if (pair_q == 2'd2) begin
            state_d = ST_COMB;
          end else begin
            state_d = ST_DOT;
          end
        end
      end
      ST_COMB: if (cnt_q == 5'd1) state_d = ST_POW;
      ST_POW:  if (cnt_q == PowLast) state_d = ST_CHAN;
      ST_CHAN: if (cnt_q == 5'd5 && ch_q == 2'd0) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: q_pop    = q_valid_i;
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ci_q        <= '0;
      vi_q        <= '0;
      pair_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        merged_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q  <= '0;
          ci_q   <= '0;
          vi_q   <= '0;
          pair_q <= '0;
          ch_q   <= 2'd2;
        end
        ST_NORM: begin
          if (ci_q == 2'd2) begin
            ci_q <= '0;
            vi_q <= vi_q + 2'd1;
          end else begin
            ci_q <= ci_q + 2'd1;
          end
        end
        ST_DOT:  ci_q  <= (ci_q == 2'd2) ? 2'd0 : ci_q + 2'd1;
        ST_PROD: cnt_q <= '0;
        ST_SQRT, ST_COMB, ST_POW: cnt_q <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
        ST_DIV: begin
          if (cnt_q == 5'd16) begin
            cnt_q  <= '0;
            pair_q <= pair_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_CHAN: begin
          if (cnt_q == 5'd5) begin
            cnt_q          <= '0;
            ch_q           <= ch_q - 2'd1;
            merged_q[ch_q] <= mnew;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          item_q   <= q_item_i;
          acc_q    <= '0;
          factor_q <= 17'd32768;
          cosv_q   <= '0;
        end
      end
      ST_NORM: begin
        if (ci_q == 2'd2) begin
          nrm_q[vi_q] <= acc_sum[31:0];
          acc_q       <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_DOT: begin
        if (ci_q == 2'd2) begin
          dneg_q <= acc_sum < 0;
          rem_q  <= {dmag, 15'b0};
          acc_q  <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      ST_PROD: begin
        sqv_q <= mul_p[63:0];
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sqv_q <= sqv_q - trial[63:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIV: begin
        if (cnt_q == 5'd0) begin
          dv_q  <= {res_q[31:0], 15'b0};
          quo_q <= '0;
        end else begin
          if (div_ge) begin
            rem_q <= rem_q - dv_q;
          end
          quo_q <= quo_nx;
          dv_q  <= dv_q >> 1;
          if (cnt_q == 5'd16) begin
            cos_q[pair_q] <= cos_nx;
            if (item_q.kind == KIND_DIFFUSE) begin
              cosv_q   <= cos_nx;
              factor_q <= (cos_nx > 0) ? {1'b0, cos_nx} : 17'd0;
            end
          end
        end
      end
      ST_COMB: begin
        if (cnt_q == 5'd0) begin
          comb_q <= mul_p[32:0];
        end else begin
          cosv_q <= sat_cos;
          base_q <= (sat_cos > 0) ? sat_cos : 16'd0;
          pres_q <= 17'd32768;
          expo_q <= item_q.expo;
        end
      end
      ST_POW: begin
        // even cycle multiplies the result, odd cycle squares the base
        if (!cnt_q[0]) begin
          if (expo_q[0]) begin
            pres_q <= mul_p[31:15];
          end
        end else begin
          base_q <= mul_p[30:15];
          expo_q <= expo_q >> 1;
        end
        if (cnt_q == PowLast) begin
          factor_q <= pres_q;
        end
      end
      ST_CHAN: begin
        case (cnt_q)
          5'd0: kl_q <= mul_p[23:0];
          5'd1: prod_q <= mul_p[39:0];
          5'd2: begin
            q0_q <= mul_p[49:32];
            t8_q <= t8;
          end
          5'd3: level_q <= level;
          5'd4: p_q <= mul_p[32:16];
          5'd5: begin
            term_acc_q[ch_q] <= t8_q;
            mrg_acc_q[ch_q]  <= m8;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          term_out_q <= term_acc_q;
          mrg_out_q  <= mrg_acc_q;
          cos_out_q  <= cosv_q;
        end
      end
      default: ;
    endcase
  end

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (bit_q != '0))
    else $error("square root ran out of bits");

  a_pow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POW) |-> (pres_q <= 17'd32768))
    else $error("power result above one");

  a_chan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHAN) |-> (ch_q != 2'd3))
    else $error("channel index out of range");

endmodule

@@ rtl/core/phong_light_term_accumulator.sv @@
// one item at a time through a shared 33x33 multiplier sequencer
// ambient/reflection skip the cosines; diffuse computes one, specular three plus the power
// diffuse/specular cost: one-bit-a-cycle square root (32 bits) and divider (16 bits) per cosine
// result is registered from ST_DONE unless stalled; a 2-item queue takes inputs meanwhile
// rst_ni is asynchronous, active low: clears the queue, the sequencer and merged levels to zero
module phong_light_term_accumulator import plt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic               start_req_i,
  input  logic [23:0]        light_rgb_i,
  input  logic [47:0]        coeff_rgb_i,
  input  logic [47:0]        normal_vec_i,
  input  logic [47:0]        light_vec_i,
  input  logic [47:0]        view_vec_i,
  input  logic [7:0]         shininess_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        term_rgb_o,
  output logic [23:0]        merged_rgb_o,
  output logic signed [15:0] cosine_o
);

  logic      q_full, q_push, q_valid, q_pop;
  plt_item_t push_item, head_item;

  plt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .start_req_i  (start_req_i),
    .light_rgb_i  (light_rgb_i),
    .coeff_rgb_i  (coeff_rgb_i),
    .normal_vec_i (normal_vec_i),
    .light_vec_i  (light_vec_i),
    .view_vec_i   (view_vec_i),
    .shininess_i  (shininess_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  plt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  plt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .term_rgb_o   (term_rgb_o),
    .merged_rgb_o (merged_rgb_o),
    .cosine_o     (cosine_o)
  );

endmodule
